FILE: rtl/core/pcorr_pkg.sv
// ----------------------------------------------------------------------------
// pcorr_pkg
// Types and constants shared by the correlation controller and datapath.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  localparam int CNT_W  = 13;   // pair count
  localparam int SMP_W  = 16;   // sample port width
  localparam int SX_W   = 28;   // sum of x, sum of y
  localparam int SXY_W  = 44;   // sum of x*y
  localparam int SXX_W  = 43;   // sum of x*x, sum of y*y
  localparam int OP_W   = 58;   // multiplier operand, a / b / c
  localparam int PROD_W = 116;  // multiplier product
  localparam int ROOT_W = 148;  // root search accumulators
  localparam int Q_W    = 16;   // coefficient width
  localparam int MCNT_W = 6;    // multiplier iteration counter

  typedef struct packed {
    logic signed [SMP_W-1:0] x_sample;
    logic signed [SMP_W-1:0] y_sample;
    logic                    last_pair;
  } pc_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] correlation_q15;
    logic [CNT_W-1:0]      pair_count;
    logic                  degenerate;
    logic                  overflowed;
  } pc_out_t;

  typedef enum logic [2:0] {
    SEL_N_SXY,
    SEL_SX_SY,
    SEL_N_SXX,
    SEL_SX_SX,
    SEL_N_SYY,
    SEL_SY_SY,
    SEL_AA,
    SEL_BC
  } pc_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MSTART,
    ST_MWAIT,
    ST_CHECK,
    ST_RINIT,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_FINISH
  } pc_state_t;

  typedef struct packed {
    logic    capture;
    logic    accum;
    logic    mul_start;
    logic    mul_store;
    pc_sel_t sel;
    logic    root_init;
    logic    root_add1;
    logic    root_add2;
    logic    root_cmp;
    logic    load_out;
  } pc_cmd_t;

  typedef struct packed {
    logic last;
    logic mul_done;
    logic degen;
    logic root_done;
    logic out_full;
  } pc_sts_t;

endpackage

FILE: rtl/core/pcorr_mul.sv
// ----------------------------------------------------------------------------
// pcorr_mul
// Signed shift-add multiplier, one operand bit per cycle, registered product.
// ----------------------------------------------------------------------------
module pcorr_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pcorr_pkg::OP_W-1:0]   op_a,
  input  logic signed [pcorr_pkg::OP_W-1:0]   op_b,
  output logic                                done,
  output logic [pcorr_pkg::PROD_W-1:0]        prod
);

  logic [pcorr_pkg::OP_W-1:0]   mag_a;
  logic [pcorr_pkg::PROD_W-1:0] acc;
  logic [pcorr_pkg::OP_W:0]     sum;
  logic [pcorr_pkg::MCNT_W-1:0] cnt;
  logic                         neg;
  logic                         busy;
  logic                         fin;

  assign sum = {1'b0, acc[pcorr_pkg::PROD_W-1:pcorr_pkg::OP_W]}
             + {1'b0, (acc[0] ? mag_a : '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        cnt   <= '0;
        mag_a <= op_a[pcorr_pkg::OP_W-1] ? -op_a : op_a;
        acc   <= {{pcorr_pkg::OP_W{1'b0}}, (op_b[pcorr_pkg::OP_W-1] ? -op_b : op_b)};
        neg   <= op_a[pcorr_pkg::OP_W-1] ^ op_b[pcorr_pkg::OP_W-1];
      end else if (busy) begin
        done <= 1'b0;
        acc  <= {sum, acc[pcorr_pkg::OP_W-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == pcorr_pkg::MCNT_W'(pcorr_pkg::OP_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        prod <= neg ? -acc : acc;
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/pcorr_dp.sv
// ----------------------------------------------------------------------------
// pcorr_dp
// Running sums, final a/b/c terms, bitwise root-quotient search, result reg.
// ----------------------------------------------------------------------------
module pcorr_dp #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pcorr_pkg::pc_in_t  in_data,
  input  pcorr_pkg::pc_cmd_t cmd,
  output pcorr_pkg::pc_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output pcorr_pkg::pc_out_t out_data
);

  localparam int OP_W   = pcorr_pkg::OP_W;
  localparam int ROOT_W = pcorr_pkg::ROOT_W;
  localparam int Q_W    = pcorr_pkg::Q_W;

  logic signed [SAMPLE_BITS-1:0]  xs, ys;
  logic signed [15:0]             x16, y16;
  logic signed [15:0]             xr, yr;
  logic                           last_r;
  logic signed [31:0]             pxy, pxx, pyy;

  logic [pcorr_pkg::CNT_W-1:0]         count;
  logic signed [pcorr_pkg::SX_W-1:0]   sum_x, sum_y;
  logic signed [pcorr_pkg::SXY_W-1:0]  sum_xy;
  logic [pcorr_pkg::SXX_W-1:0]         sum_xx, sum_yy;
  logic                                dropped;

  logic signed [OP_W-1:0] op_a, op_b, n_op;
  logic signed [OP_W-1:0] tmp, ta, tb, tc;
  logic                   mul_done;
  logic [pcorr_pkg::PROD_W-1:0] prod;

  logic [ROOT_W-1:0] lim, qq, e, f, s;
  logic [Q_W-1:0]    q, mask;
  logic              take;
  logic signed [Q_W-1:0] coef;

  assign xs  = in_data.x_sample[SAMPLE_BITS-1:0];
  assign ys  = in_data.y_sample[SAMPLE_BITS-1:0];
  assign x16 = 16'(xs);
  assign y16 = 16'(ys);
  assign n_op = OP_W'({1'b0, count});

  // multiplier operand select
  always_comb begin
    unique case (cmd.sel)
      pcorr_pkg::SEL_N_SXY: begin op_a = n_op;         op_b = OP_W'(sum_xy); end
      pcorr_pkg::SEL_SX_SY: begin op_a = OP_W'(sum_x); op_b = OP_W'(sum_y);  end
      pcorr_pkg::SEL_N_SXX: begin op_a = n_op;         op_b = OP_W'({1'b0, sum_xx}); end
      pcorr_pkg::SEL_SX_SX: begin op_a = OP_W'(sum_x); op_b = OP_W'(sum_x);  end
      pcorr_pkg::SEL_N_SYY: begin op_a = n_op;         op_b = OP_W'({1'b0, sum_yy}); end
      pcorr_pkg::SEL_SY_SY: begin op_a = OP_W'(sum_y); op_b = OP_W'(sum_y);  end
      pcorr_pkg::SEL_AA:    begin op_a = ta;           op_b = ta;            end
      pcorr_pkg::SEL_BC:    begin op_a = tb;           op_b = tc;            end
      default:              begin op_a = '0;           op_b = '0;            end
    endcase
  end

  pcorr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_start),
    .op_a (op_a),
    .op_b (op_b),
    .done (mul_done),
    .prod (prod)
  );

  assign take = !q[Q_W-1] && (s <= lim);

  always_comb begin
    if (!ta[OP_W-1]) coef = q[Q_W-1] ? Q_W'(16'sd32767) : $signed(q);
    else             coef = $signed(-q);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xr     <= x16;
      yr     <= y16;
      last_r <= in_data.last_pair;
      pxy    <= x16 * y16;
      pxx    <= x16 * x16;
      pyy    <= y16 * y16;
    end
    if (cmd.mul_store) begin
      unique case (cmd.sel)
        pcorr_pkg::SEL_N_SXY,
        pcorr_pkg::SEL_N_SXX,
        pcorr_pkg::SEL_N_SYY: tmp <= prod[OP_W-1:0];
        pcorr_pkg::SEL_SX_SY: ta  <= tmp - prod[OP_W-1:0];
        pcorr_pkg::SEL_SX_SX: tb  <= tmp - prod[OP_W-1:0];
        pcorr_pkg::SEL_SY_SY: tc  <= tmp - prod[OP_W-1:0];
        pcorr_pkg::SEL_AA:    lim <= ROOT_W'(prod) << 30;
        pcorr_pkg::SEL_BC:    f   <= ROOT_W'(prod) << 30;
        default: ;
      endcase
    end
    // e tracks q*bc shifted to the current bit, f tracks bc at twice that shift
    if (cmd.root_init) begin
      q    <= '0;
      qq   <= '0;
      e    <= '0;
      mask <= {1'b1, {(Q_W-1){1'b0}}};
    end
    if (cmd.root_add1) s <= qq + e;
    if (cmd.root_add2) s <= s + f;
    if (cmd.root_cmp) begin
      if (take) begin
        qq <= s;
        q  <= q | mask;
        e  <= (e >> 1) + f;
      end else begin
        e  <= e >> 1;
      end
      f    <= f >> 2;
      mask <= mask >> 1;
    end
    if (cmd.load_out) begin
      out_data.correlation_q15 <= sts.degen ? '0 : coef;
      out_data.pair_count      <= count;
      out_data.degenerate      <= sts.degen;
      out_data.overflowed      <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_xy    <= '0;
      sum_xx    <= '0;
      sum_yy    <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accum) begin
        if (count < pcorr_pkg::CNT_W'(MAX_PAIRS)) begin
          count  <= count + 1'b1;
          sum_x  <= sum_x + pcorr_pkg::SX_W'(xr);
          sum_y  <= sum_y + pcorr_pkg::SX_W'(yr);
          sum_xy <= sum_xy + pcorr_pkg::SXY_W'(pxy);
          sum_xx <= sum_xx + pcorr_pkg::SXX_W'($unsigned(pxx));
          sum_yy <= sum_yy + pcorr_pkg::SXX_W'($unsigned(pyy));
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        count     <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
        sum_xy    <= '0;
        sum_xx    <= '0;
        sum_yy    <= '0;
        dropped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.last      = last_r;
  assign sts.mul_done  = mul_done;
  assign sts.degen     = (ta == '0) || tb[OP_W-1] || (tb == '0) || tc[OP_W-1] || (tc == '0);
  assign sts.root_done = mask[0];
  assign sts.out_full  = out_valid && !out_ready;

endmodule

FILE: rtl/core/pcorr_ctrl.sv
// ----------------------------------------------------------------------------
// pcorr_ctrl
// Sequencer: pair intake, multiply schedule, root search, result hand-off.
// ----------------------------------------------------------------------------
module pcorr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcorr_pkg::pc_sts_t sts,
  output pcorr_pkg::pc_cmd_t cmd
);

  pcorr_pkg::pc_state_t state, state_next;
  pcorr_pkg::pc_sel_t   sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcorr_pkg::ST_IDLE;
      sel   <= pcorr_pkg::SEL_N_SXY;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    unique case (state)
      pcorr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = pcorr_pkg::ST_ACC;
        end
      end
      pcorr_pkg::ST_ACC: begin
        cmd.accum = 1'b1;
        if (sts.last) begin
          sel_next   = pcorr_pkg::SEL_N_SXY;
          state_next = pcorr_pkg::ST_MSTART;
        end else begin
          state_next = pcorr_pkg::ST_IDLE;
        end
      end
      pcorr_pkg::ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_next    = pcorr_pkg::ST_MWAIT;
      end
      pcorr_pkg::ST_MWAIT: begin
        if (sts.mul_done) begin
          cmd.mul_store = 1'b1;
          unique case (sel)
            pcorr_pkg::SEL_N_SXY: begin sel_next = pcorr_pkg::SEL_SX_SY; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_SX_SY: begin sel_next = pcorr_pkg::SEL_N_SXX; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_N_SXX: begin sel_next = pcorr_pkg::SEL_SX_SX; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_SX_SX: begin sel_next = pcorr_pkg::SEL_N_SYY; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_N_SYY: begin sel_next = pcorr_pkg::SEL_SY_SY; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_SY_SY: state_next = pcorr_pkg::ST_CHECK;
            pcorr_pkg::SEL_AA:    begin sel_next = pcorr_pkg::SEL_BC; state_next = pcorr_pkg::ST_MSTART; end
            pcorr_pkg::SEL_BC:    state_next = pcorr_pkg::ST_RINIT;
            default:              state_next = pcorr_pkg::ST_IDLE;
          endcase
        end
      end
      pcorr_pkg::ST_CHECK: begin
        if (sts.degen) begin
          state_next = pcorr_pkg::ST_FINISH;
        end else begin
          sel_next   = pcorr_pkg::SEL_AA;
          state_next = pcorr_pkg::ST_MSTART;
        end
      end
      pcorr_pkg::ST_RINIT: begin
        cmd.root_init = 1'b1;
        state_next    = pcorr_pkg::ST_R1;
      end
      pcorr_pkg::ST_R1: begin
        cmd.root_add1 = 1'b1;
        state_next    = pcorr_pkg::ST_R2;
      end
      pcorr_pkg::ST_R2: begin
        cmd.root_add2 = 1'b1;
        state_next    = pcorr_pkg::ST_R3;
      end
      pcorr_pkg::ST_R3: begin
        cmd.root_cmp = 1'b1;
        state_next   = sts.root_done ? pcorr_pkg::ST_FINISH : pcorr_pkg::ST_R1;
      end
      pcorr_pkg::ST_FINISH: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = pcorr_pkg::ST_IDLE;
        end
      end
      default: state_next = pcorr_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/pearson_correlation_unit.sv
// Plain pair: captured with its products, then accumulated; no result.
// Last pair: captured and accumulated, then 8 serial multiplies, a check,
// a bitwise root search and a load of the result (a degenerate run skips the
// last two multiplies and the root search). All multiplies share the one
// shift-add multiplier. Synchronous reset clears the sums, the count, the drop
// flag and out_valid.
// ----------------------------------------------------------------------------
// pearson_correlation_unit
// Correlation coefficient of a run of signed sample pairs, Q1.15 result.
// ----------------------------------------------------------------------------
module pearson_correlation_unit #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcorr_pkg::pc_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcorr_pkg::pc_out_t out_data
);

  pcorr_pkg::pc_cmd_t cmd;
  pcorr_pkg::pc_sts_t sts;

  pcorr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pcorr_dp #(
    .MAX_PAIRS  (MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
